/* design/rfcf_pkg.sv */
// Shared types, codes and the CRC-16/MODBUS byte update for the frame filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rfcf_pkg;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_CRC = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_SKIP = 16'hFFFF;
	localparam logic [8:0]  COUNT_MAX = 9'd511;
	localparam int          MAC_W = 48;

	typedef logic [MAC_W-1:0] mac_t;

	typedef struct packed {
		logic take;    // word accepted on the input channel
		logic finish;  // finish the held item and load the result register
	} rfcf_cmd_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* design/rfcf_if.sv */
// Channel interfaces of the frame filter: input items, results, config writes.
// Depends on rfcf_pkg for the address type.
`default_nettype none

interface rfcf_in_if;
	import rfcf_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;
	logic       last_byte;
	mac_t       sender_mac;
	logic [3:0] entry_index;

	modport source(output valid, op, data_byte, last_byte, sender_mac, entry_index,
		input ready);
	modport sink(input valid, op, data_byte, last_byte, sender_mac, entry_index,
		output ready);
endinterface

interface rfcf_out_if;
	import rfcf_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       new_peer;
	logic [3:0] found_count;
	mac_t       target_mac;
	logic       entry_valid;
	mac_t       entry_mac;

	modport source(output valid, status, new_peer, found_count, target_mac, entry_valid,
		entry_mac, input ready);
	modport sink(input valid, status, new_peer, found_count, target_mac, entry_valid,
		entry_mac, output ready);
endinterface

interface rfcf_cfg_if;
	logic valid;
	logic ready;
	logic scan_enable;

	modport source(output valid, scan_enable, input ready);
	modport sink(input valid, scan_enable, output ready);
endinterface

`default_nettype wire

/* design/rfcf_ctrl.sv */
// Controller: accepts words, steps into the finish state for frame ends,
// clears and reads, and owns the result valid flag. Depends on rfcf_pkg.
`default_nettype none

module rfcf_ctrl import rfcf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rx_valid,
	input  wire logic [1:0] rx_op,
	input  wire logic      rx_last,
	output logic           rx_ready,
	output logic           res_valid,
	input  wire logic      res_ready,
	output rfcf_cmd_t      cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_FINISH = 1'b1;

	logic state_q;
	logic state_d;
	logic res_valid_q;
	logic needs_finish;

	assign rx_ready   = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign cmd.take   = rx_valid && rx_ready;
	assign cmd.finish = (state_q == S_FINISH) && (!res_valid_q || res_ready);

	always_comb begin
		needs_finish = (rx_op inside {OP_CLEAR, OP_READ}) || (rx_op == OP_FRAME && rx_last);
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.take && needs_finish) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (cmd.finish) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/rfcf_datapath.sv */
// Datapath: running CRC, tail bytes, byte count, found table, target and
// the result register. Driven by rfcf_ctrl commands; depends on rfcf_pkg.
`default_nettype none

module rfcf_datapath import rfcf_pkg::*; #(
	parameter int PACKET_BYTES = 64,
	parameter int FOUND_DEPTH  = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rfcf_cmd_t  cmd,
	input  wire logic [1:0] rx_op,
	input  wire logic [7:0] rx_data_byte,
	input  wire mac_t       rx_sender_mac,
	input  wire logic [3:0] rx_entry_index,
	input  wire logic       cfg_we,
	input  wire logic       cfg_scan_enable,
	output logic [1:0]      status,
	output logic            new_peer,
	output logic [3:0]      found_count,
	output mac_t            target_mac,
	output logic            entry_valid,
	output mac_t            entry_mac
);

	localparam int IDX_W = (FOUND_DEPTH > 1) ? $clog2(FOUND_DEPTH) : 1;
	localparam logic [3:0] DEPTH_4 = 4'(FOUND_DEPTH);
	localparam logic [8:0] PKT_9 = 9'(PACKET_BYTES);

	logic        scan_en_q;
	logic [15:0] crc_q;
	logic [15:0] tail_q;
	logic [8:0]  count_q;
	logic [3:0]  total_q;
	mac_t        target_q;
	mac_t        table_q [FOUND_DEPTH];

	logic [1:0]  op_q;
	mac_t        mac_q;
	logic [3:0]  idx_q;

	logic        seen;
	logic        add;
	logic [1:0]  status_d;
	logic [15:0] recv;
	logic        rd_ok;

	// Frame state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q <= 1'b0;
			crc_q     <= CRC_INIT;
			tail_q    <= '0;
			count_q   <= '0;
			total_q   <= '0;
			target_q  <= '1;
		end else begin
			if (cfg_we) scan_en_q <= cfg_scan_enable;
			if (cmd.take && rx_op == OP_FRAME) begin
				if (count_q >= 9'd2) crc_q <= crc_feed(crc_q, tail_q[15:8]);
				tail_q <= {tail_q[7:0], rx_data_byte};
				if (count_q != COUNT_MAX) count_q <= count_q + 9'd1;
			end
			if (cmd.finish) begin
				case (op_q)
					OP_FRAME: begin
						if (add) total_q <= total_q + 4'd1;
						if (status_d == ST_OK) target_q <= mac_q;
						crc_q   <= CRC_INIT;
						tail_q  <= '0;
						count_q <= '0;
					end
					OP_CLEAR: total_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// Held item and table contents.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= rx_op;
			mac_q <= rx_sender_mac;
			idx_q <= rx_entry_index;
		end
		if (cmd.finish && op_q == OP_FRAME && add) begin
			table_q[total_q[IDX_W-1:0]] <= mac_q;
		end
	end

	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < FOUND_DEPTH; i++) begin
			if (4'(i) < total_q && table_q[i] == mac_q) seen = 1'b1;
		end
		add  = scan_en_q && !seen && (total_q < DEPTH_4);
		recv = {tail_q[7:0], tail_q[15:8]};
		if (count_q != PKT_9) begin
			status_d = ST_LEN;
		end else if (recv != CRC_SKIP && recv != crc_q) begin
			status_d = ST_CRC;
		end else begin
			status_d = ST_OK;
		end
		rd_ok = (idx_q < total_q) && (idx_q < DEPTH_4);
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status      <= ST_OK;
			new_peer    <= 1'b0;
			found_count <= total_q;
			target_mac  <= target_q;
			entry_valid <= 1'b0;
			entry_mac   <= '0;
			case (op_q)
				OP_FRAME: begin
					status      <= status_d;
					new_peer    <= add;
					found_count <= add ? total_q + 4'd1 : total_q;
					target_mac  <= (status_d == ST_OK) ? mac_q : target_q;
				end
				OP_CLEAR: found_count <= '0;
				OP_READ: begin
					entry_valid <= rd_ok;
					entry_mac   <= rd_ok ? table_q[idx_q[IDX_W-1:0]] : '0;
				end
				default: ;
			endcase
		end
	end

	ap_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= DEPTH_4) else $error("found table count beyond depth");

	ap_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && op_q == OP_FRAME |=> count_q == 9'd0 && crc_q == CRC_INIT)
		else $error("frame state not restarted after frame end");

	ap_shrink_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		total_q < $past(total_q) |-> $past(cmd.finish && op_q == OP_CLEAR))
		else $error("found table shrank without a clear");

endmodule

`default_nettype wire

/* design/rx_frame_crc_filter_peer_scan.sv */
// Received-frame CRC-16/MODBUS filter with a deduplicated peer scan table.
// Flow: a non-final frame byte is absorbed at its accept edge; a final byte, clear or read
// enters the finish state, which compares and writes the found table and loads the result
// word once the result register is free. Throughput: one byte per cycle inside a frame
// while no finish is pending; input ready stays low for the whole finish state.
// Reset: found table empty, CRC at 0xFFFF, byte count zero, target all ones, scan off.
`default_nettype none

module rx_frame_crc_filter_peer_scan import rfcf_pkg::*; #(
	parameter int PACKET_BYTES = 64,
	parameter int FOUND_DEPTH  = 10
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rfcf_in_if.sink     rx,
	rfcf_out_if.source  res,
	rfcf_cfg_if.sink    cfg
);

	rfcf_cmd_t cmd;
	logic      rx_ready;
	logic      res_valid;

	// Config writes land at once; the register only matters at frame end.
	assign cfg.ready = 1'b1;

	assign rx.ready  = rx_ready;
	assign res.valid = res_valid;

	// Controller: hold input ready low while an item is finishing, and hold
	// the finished word in the result register until the sink takes it.
	rfcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_op     (rx.op),
		.rx_last   (rx.last_byte),
		.rx_ready  (rx_ready),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.cmd       (cmd)
	);

	// Datapath: advance CRC and tail bytes per frame byte, then at frame end record
	// the sender and judge length and CRC; frame ends, clears and reads load the result register.
	rfcf_datapath #(
		.PACKET_BYTES (PACKET_BYTES),
		.FOUND_DEPTH  (FOUND_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rx_op           (rx.op),
		.rx_data_byte    (rx.data_byte),
		.rx_sender_mac   (rx.sender_mac),
		.rx_entry_index  (rx.entry_index),
		.cfg_we          (cfg.valid),
		.cfg_scan_enable (cfg.scan_enable),
		.status          (res.status),
		.new_peer        (res.new_peer),
		.found_count     (res.found_count),
		.target_mac      (res.target_mac),
		.entry_valid     (res.entry_valid),
		.entry_mac       (res.entry_mac)
	);

endmodule

`default_nettype wire

/* tb/sv/rx_frame_crc_filter_peer_scan_tb.sv */
// Self-checking testbench for rx_frame_crc_filter_peer_scan: CRC-16/MODBUS frame filter
// with a deduplicated peer scan table. Uses rfcf_pkg and the rfcf channel interfaces.
// Random idling on both channels, a built-in predictor and a per-field result check.

module rx_frame_crc_filter_peer_scan_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfcf_pkg::*;

	localparam int PACKET_BYTES  = 64;
	localparam int FOUND_DEPTH   = 10;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int POOL_SIZE     = 16;

	// What to put in the two trailing CRC bytes of a generated frame.
	typedef enum {FCS_GOOD, FCS_BAD, FCS_SKIP} fcs_kind_t;

	typedef struct {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic       last_byte;
		mac_t       sender_mac;
		logic [3:0] entry_index;
	} rx_word_t;

	typedef struct {
		logic [1:0] status;
		logic       new_peer;
		logic [3:0] found_count;
		mac_t       target_mac;
		logic       entry_valid;
		mac_t       entry_mac;
	} peer_result_t;

	logic clk;
	logic arst_n;

	rfcf_in_if  rx_ch ();
	rfcf_out_if res_ch ();
	rfcf_cfg_if cfg_ch ();

	rx_frame_crc_filter_peer_scan #(
		.PACKET_BYTES(PACKET_BYTES),
		.FOUND_DEPTH (FOUND_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// Words waiting for the driver, and filter outcomes waiting for the DUT.
	rx_word_t     pending_words [$];
	peer_result_t due_results [$];

	// Predictor state: a private copy of the filter's table, CRC and counters.
	mac_t        peer_table [FOUND_DEPTH];
	logic [3:0]  peer_total;
	logic [15:0] crc_acc;
	logic [15:0] tail_pair;
	logic [8:0]  frame_len;
	mac_t        target_addr;
	logic        scan_on;

	mac_t mac_pool [POOL_SIZE];

	bit rx_busy;
	bit rx_took;
	bit idle_on;
	int rx_gap;
	int res_gap;
	int stim_count;
	int mismatches;
	int cycle_count;

	always #4 clk = ~clk;

	// Bit-serial CRC-16/MODBUS update, LSB of the byte first.
	function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic mac_t rand_mac();
		mac_t m;
		m[31:0]  = $urandom;
		m[47:32] = $urandom_range(0, 65535);
		return m;
	endfunction

	// Advance the predictor by one accepted word; queue the outcome if the word yields one.
	task automatic filter_word(input rx_word_t w);
		peer_result_t r;
		logic         seen;
		logic [15:0]  rcv_crc;
		r = '{default: '0};
		r.status = ST_OK;
		if (w.op == OP_NONE) begin
			return;
		end
		if (w.op == OP_FRAME) begin
			// The CRC runs two bytes behind: the last two bytes of a frame are its FCS.
			if (frame_len >= 2) begin
				crc_acc = modbus_crc_byte(crc_acc, tail_pair[15:8]);
			end
			tail_pair = {tail_pair[7:0], w.data_byte};
			if (frame_len != COUNT_MAX) begin
				frame_len = frame_len + 1'b1;
			end
			if (!w.last_byte) begin
				return;
			end
			// Record the sender before any length or CRC verdict.
			if (scan_on) begin
				seen = 1'b0;
				for (int i = 0; i < FOUND_DEPTH; i++) begin
					if (i < peer_total && peer_table[i] == w.sender_mac) begin
						seen = 1'b1;
					end
				end
				if (!seen && peer_total < FOUND_DEPTH) begin
					peer_table[peer_total] = w.sender_mac;
					peer_total = peer_total + 1'b1;
					r.new_peer = 1'b1;
				end
			end
			if (frame_len != PACKET_BYTES) begin
				r.status = ST_LEN;
			end else begin
				rcv_crc = {tail_pair[7:0], tail_pair[15:8]};
				if (rcv_crc != CRC_SKIP && rcv_crc != crc_acc) begin
					r.status = ST_CRC;
				end
			end
			if (r.status == ST_OK) begin
				target_addr = w.sender_mac;
			end
			crc_acc   = CRC_INIT;
			tail_pair = '0;
			frame_len = '0;
		end else if (w.op == OP_CLEAR) begin
			for (int i = 0; i < FOUND_DEPTH; i++) begin
				peer_table[i] = '0;
			end
			peer_total = '0;
		end else begin
			if (w.entry_index < peer_total) begin
				r.entry_valid = 1'b1;
				r.entry_mac   = peer_table[w.entry_index];
			end
		end
		r.found_count = peer_total;
		r.target_mac  = target_addr;
		due_results.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [47:0] want,
		input logic [47:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic push_word(input logic [1:0] op, input logic [7:0] d, input logic l,
		input mac_t m, input logic [3:0] idx);
		rx_word_t w;
		w.op          = op;
		w.data_byte   = d;
		w.last_byte   = l;
		w.sender_mac  = m;
		w.entry_index = idx;
		pending_words.push_back(w);
		if (op != OP_NONE) begin
			stim_count++;
		end
	endtask

	// Side words carry random junk in the fields they do not use.
	task automatic push_read(input logic [3:0] idx);
		push_word(OP_READ, $urandom_range(0, 255), $urandom_range(0, 1), rand_mac(), idx);
	endtask

	task automatic push_clear();
		push_word(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1), rand_mac(),
			$urandom_range(0, 15));
	endtask

	task automatic push_noise();
		push_word(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 1), rand_mac(),
			$urandom_range(0, 15));
	endtask

	// Build one frame of len bytes. mix 1 sprinkles side words between bytes at random,
	// mix 2 puts a read, a clear and an undefined op at fixed byte positions.
	task automatic add_frame(input int len, input mac_t mac, input fcs_kind_t fcs,
		input int mix);
		logic [7:0]  body [$];
		logic [15:0] crc;
		logic [15:0] fcs_val;
		int          pick;
		crc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			body.push_back($urandom_range(0, 255));
		end
		if (len >= 2) begin
			for (int i = 0; i < len - 2; i++) begin
				crc = modbus_crc_byte(crc, body[i]);
			end
			case (fcs)
				FCS_GOOD: begin
					fcs_val = crc;
				end
				FCS_SKIP: begin
					fcs_val = CRC_SKIP;
				end
				default: begin
					do begin
						fcs_val = crc ^ $urandom_range(1, 65535);
					end while (fcs_val == CRC_SKIP);
				end
			endcase
			body[len-2] = fcs_val[7:0];
			body[len-1] = fcs_val[15:8];
		end
		for (int i = 0; i < len; i++) begin
			if (mix == 1 && i > 0 && $urandom_range(0, 49) == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					push_read($urandom_range(0, 15));
				end else if (pick < 8) begin
					push_noise();
				end else begin
					push_clear();
				end
			end
			if (mix == 2) begin
				if (i == 10) begin
					push_read(0);
				end else if (i == 20) begin
					push_clear();
				end else if (i == 30) begin
					push_noise();
				end
			end
			push_word(OP_FRAME, body[i], i == len - 1, mac, $urandom_range(0, 15));
		end
	endtask

	// Random traffic: mostly well-formed frames from a small sender pool, so the table
	// fills and dedups, plus short and wrong-length frames, reads, clears and noise.
	task automatic run_random(input int count);
		int        start;
		int        pick;
		int        k;
		mac_t      m;
		fcs_kind_t f;
		start = stim_count;
		while (stim_count - start < count) begin
			pick = $urandom_range(0, 99);
			m = ($urandom_range(0, 4) == 0) ? rand_mac() : mac_pool[$urandom_range(0, POOL_SIZE - 1)];
			k = $urandom_range(0, 19);
			f = (k < 14) ? FCS_GOOD : ((k < 17) ? FCS_BAD : FCS_SKIP);
			if (pick < 45) begin
				add_frame(PACKET_BYTES, m, f, 1);
			end else if (pick < 62) begin
				add_frame($urandom_range(1, 12), m, f, 0);
			end else if (pick < 66) begin
				k = $urandom_range(PACKET_BYTES - 4, PACKET_BYTES + 4);
				add_frame((k == PACKET_BYTES) ? k + 1 : k, m, f, 1);
			end else if (pick < 84) begin
				push_read($urandom_range(0, 15));
			end else if (pick < 90) begin
				push_clear();
			end else begin
				push_noise();
			end
		end
	endtask

	// Wait until every word is taken and every outcome has come back, then let the
	// pipeline empty before touching the register.
	task automatic drain();
		while (pending_words.size() != 0 || rx_busy) begin
			@(posedge clk);
		end
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scan(input logic v);
		@(negedge clk);
		cfg_ch.scan_enable <= v;
		cfg_ch.valid       <= 1'b1;
		do begin
			@(posedge clk);
		end while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Input driver: present one word at a time, hold it until taken, then maybe back off.
	always @(negedge clk) begin : rx_drive
		rx_word_t w;
		if (rx_busy && rx_took) begin
			rx_busy = 1'b0;
		end
		if (!rx_busy) begin
			if (rx_gap > 0) begin
				rx_gap--;
				rx_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				rx_ch.op          <= w.op;
				rx_ch.data_byte   <= w.data_byte;
				rx_ch.last_byte   <= w.last_byte;
				rx_ch.sender_mac  <= w.sender_mac;
				rx_ch.entry_index <= w.entry_index;
				rx_ch.valid       <= 1'b1;
				rx_busy = 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) begin
					rx_gap = $urandom_range(1, 9);
				end
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: hold ready low in random bursts while idling is on.
	always @(negedge clk) begin
		if (res_gap > 0) begin
			res_gap--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 6) == 0) begin
				res_gap = $urandom_range(1, 9);
			end
		end
	end

	// Monitor: predict on each taken word first, then check each delivered result,
	// so a same-edge result still finds its outcome queued.
	always @(posedge clk) begin : watch
		rx_word_t     w;
		peer_result_t want;
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("rx_frame_crc_filter_peer_scan test failed");
			$finish;
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			scan_on = cfg_ch.scan_enable;
		end
		rx_took = rx_ch.valid && rx_ch.ready;
		if (rx_took) begin
			w.op          = rx_ch.op;
			w.data_byte   = rx_ch.data_byte;
			w.last_byte   = rx_ch.last_byte;
			w.sender_mac  = rx_ch.sender_mac;
			w.entry_index = rx_ch.entry_index;
			filter_word(w);
		end
		if (res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t ns: result word with none expected, status %0d target 0x%0h",
					$time, res_ch.status, res_ch.target_mac);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("status", want.status, res_ch.status);
				check_field("new_peer", want.new_peer, res_ch.new_peer);
				check_field("found_count", want.found_count, res_ch.found_count);
				check_field("target_mac", want.target_mac, res_ch.target_mac);
				check_field("entry_valid", want.entry_valid, res_ch.entry_valid);
				check_field("entry_mac", want.entry_mac, res_ch.entry_mac);
			end
		end
	end

	initial begin : stimulus
		mac_t first_mac;
		clk    = 1'b0;
		arst_n = 1'b0;
		rx_ch.valid        = 1'b0;
		rx_ch.op           = OP_FRAME;
		rx_ch.data_byte    = '0;
		rx_ch.last_byte    = 1'b0;
		rx_ch.sender_mac   = '0;
		rx_ch.entry_index  = '0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.scan_enable = 1'b0;
		rx_busy     = 1'b0;
		rx_took     = 1'b0;
		idle_on     = 1'b1;
		rx_gap      = 0;
		res_gap     = 0;
		stim_count  = 0;
		mismatches  = 0;
		cycle_count = 0;

		// Predictor starts from the reset state.
		for (int i = 0; i < FOUND_DEPTH; i++) begin
			peer_table[i] = '0;
		end
		peer_total  = '0;
		crc_acc     = CRC_INIT;
		tail_pair   = '0;
		frame_len   = '0;
		target_addr = '1;
		scan_on     = 1'b0;

		// Sender pool: both address extremes plus random ones, more than the table holds.
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			mac_pool[i] = rand_mac();
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Scan off: a good frame is accepted but its sender is not recorded.
		write_scan(1'b0);
		add_frame(PACKET_BYTES, mac_pool[2], FCS_GOOD, 0);
		push_read(0);
		drain();

		// Scan on: address extremes, CRC skip and mismatch, length errors, saturation.
		write_scan(1'b1);
		add_frame(PACKET_BYTES, mac_pool[0], FCS_GOOD, 0);
		add_frame(PACKET_BYTES, mac_pool[1], FCS_SKIP, 2);
		add_frame(PACKET_BYTES, mac_pool[3], FCS_BAD, 0);
		add_frame(1, mac_pool[4], FCS_GOOD, 0);
		add_frame(2, mac_pool[5], FCS_GOOD, 0);
		add_frame(PACKET_BYTES - 1, mac_pool[6], FCS_GOOD, 0);
		add_frame(PACKET_BYTES + 1, mac_pool[7], FCS_GOOD, 0);
		// Drive past the byte counter's ceiling so it saturates.
		add_frame(520, mac_pool[8], FCS_GOOD, 0);
		push_read(0);
		push_read(1);
		push_read(15);
		// Fill the table with one-byte frames, overflow it, then repeat a sender.
		push_clear();
		first_mac = rand_mac();
		add_frame(1, first_mac, FCS_GOOD, 0);
		for (int i = 1; i <= FOUND_DEPTH; i++) begin
			add_frame(1, rand_mac(), FCS_GOOD, 0);
		end
		add_frame(1, first_mac, FCS_GOOD, 0);
		push_read(FOUND_DEPTH - 1);
		push_read(FOUND_DEPTH);
		push_noise();
		drain();

		// Random phases, alternating the scan setting.
		run_random(16);
		drain();
		write_scan(1'b0);
		run_random(16);
		drain();
		write_scan(1'b1);
		run_random(16);
		drain();

		// Final stretch runs back to back with no idling on either side.
		idle_on = 1'b0;
		write_scan($urandom_range(0, 1));
		run_random(32);
		drain();

		if (mismatches == 0) begin
			$display("rx_frame_crc_filter_peer_scan test passed");
		end else begin
			$display("rx_frame_crc_filter_peer_scan test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/rfcf_pkg.sv
design/rfcf_if.sv
design/rfcf_ctrl.sv
design/rfcf_datapath.sv
design/rx_frame_crc_filter_peer_scan.sv
tb/sv/rx_frame_crc_filter_peer_scan_tb.sv
